>>> rtl/core/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

	// Request codes; code 3 is unused and leaves the queue untouched
	typedef enum logic [1:0] {
		REQ_ENQ  = 2'd0,
		REQ_DEQ  = 2'd1,
		REQ_PEEK = 2'd2
	} req_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	localparam int DATA_W = 32;
	localparam int PRIO_PORT_W = 16;
	localparam int OCC_W = 5;

	// Per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic enq;
		logic deq;
	} cell_cmd_t;

endpackage

>>> rtl/core/sorted_priority_queue_top.sv
`timescale 1ns / 1ps

// Channel  Handshake            Payload
// in       in_valid / in_stall  req_type, item_data, item_priority
// out      out_valid / out_stall status, head_data, head_priority, occupancy
//
// One request per cycle while in_stall is low: every cell compares its entry with the new one
// at once, and the whole chain shifts together, so a result is held in the output register
// from the cycle after its request transfer.
// Reset clears all cell valid bits, the entry count and the output valid flag.
// in_stall is raised only while a result waits in the output register and
// out_stall is high; a new request is taken in the cycle the result leaves.
module sorted_priority_queue_top #(
	parameter int CAPACITY      = 16,
	parameter int PRIORITY_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         req_type,
	input  logic signed [spq_pkg::DATA_W-1:0]  item_data,
	input  logic [spq_pkg::PRIO_PORT_W-1:0]    item_priority,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [1:0]                         status,
	output logic signed [spq_pkg::DATA_W-1:0]  head_data,
	output logic [spq_pkg::PRIO_PORT_W-1:0]    head_priority,
	output logic [spq_pkg::OCC_W-1:0]          occupancy
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam int PW = PRIORITY_BITS;

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic          out_valid_q;
	logic [1:0]    status_q;
	logic [spq_pkg::DATA_W-1:0]     head_data_q;
	logic [spq_pkg::PRIO_PORT_W-1:0] head_prio_q;
	logic [CW-1:0] occ_q;

	logic                       in_xfer;
	logic                       is_enq;
	logic                       is_deq;
	logic                       is_peek;
	logic                       empty;
	logic                       full;
	spq_pkg::cell_cmd_t         cmd;
	logic [PW-1:0]              new_prio;
	logic [PW+spq_pkg::PRIO_PORT_W-1:0] prio_in_ext;
	logic [PW+spq_pkg::PRIO_PORT_W-1:0] prio_out_ext;
	logic [1:0]                 status_d;
	logic [spq_pkg::DATA_W-1:0] hd_d;
	logic [spq_pkg::PRIO_PORT_W-1:0] hp_d;
	logic [CW+spq_pkg::OCC_W-1:0] occ_ext;

	logic [spq_pkg::DATA_W-1:0] c_data    [CAPACITY];
	logic [PW-1:0]              c_prio    [CAPACITY];
	logic [CAPACITY-1:0]        c_valid;
	logic [CAPACITY-1:0]        c_greater;

	assign in_stall = out_valid_q && out_stall;
	assign in_xfer  = in_valid && !in_stall;

	// Decode the request
	assign is_enq  = (req_type == spq_pkg::REQ_ENQ);
	assign is_deq  = (req_type == spq_pkg::REQ_DEQ);
	assign is_peek = (req_type == spq_pkg::REQ_PEEK);
	assign empty   = (count_q == '0);
	assign full    = (count_q == CAP_C);

	assign cmd.enq = in_xfer && is_enq && !full;
	assign cmd.deq = in_xfer && is_deq && !empty;

	// Keep only the low priority bits
	assign prio_in_ext = {{PW{1'b0}}, item_priority};
	assign new_prio    = prio_in_ext[PW-1:0];

	// Chain of cells, head at cell 0
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [spq_pkg::DATA_W-1:0] l_data;
		logic [PW-1:0]              l_prio;
		logic                       l_valid;
		logic                       l_greater;
		logic [spq_pkg::DATA_W-1:0] r_data;
		logic [PW-1:0]              r_prio;
		logic                       r_valid;

		if (i == 0) begin : g_first
			assign l_data    = '0;
			assign l_prio    = '0;
			assign l_valid   = 1'b0;
			assign l_greater = 1'b0;
		end else begin : g_mid_l
			assign l_data    = c_data[i-1];
			assign l_prio    = c_prio[i-1];
			assign l_valid   = c_valid[i-1];
			assign l_greater = c_greater[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign r_data  = '0;
			assign r_prio  = '0;
			assign r_valid = 1'b0;
		end else begin : g_mid_r
			assign r_data  = c_data[i+1];
			assign r_prio  = c_prio[i+1];
			assign r_valid = c_valid[i+1];
		end

		spq_cell #(
			.PRIORITY_BITS(PW)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.new_data    (item_data),
			.new_prio    (new_prio),
			.left_data   (l_data),
			.left_prio   (l_prio),
			.left_valid  (l_valid),
			.left_greater(l_greater),
			.right_data  (r_data),
			.right_prio  (r_prio),
			.right_valid (r_valid),
			.data        (c_data[i]),
			.prio        (c_prio[i]),
			.valid       (c_valid[i]),
			.greater     (c_greater[i])
		);
	end

	// Track the entry count
	always_comb begin
		count_d = count_q;
		if (cmd.enq) begin
			count_d = count_q + 1'b1;
		end else if (cmd.deq) begin
			count_d = count_q - 1'b1;
		end
	end

	// Form the result from the head cell
	assign prio_out_ext = {{spq_pkg::PRIO_PORT_W{1'b0}}, c_prio[0]};

	always_comb begin
		status_d = spq_pkg::ST_OK;
		hd_d     = '0;
		hp_d     = '0;
		if (is_enq && full) begin
			status_d = spq_pkg::ST_FULL;
		end else if (is_deq || is_peek) begin
			if (empty) begin
				status_d = spq_pkg::ST_EMPTY;
			end else begin
				hd_d = c_data[0];
				hp_d = prio_out_ext[spq_pkg::PRIO_PORT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (in_xfer) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the result on each request transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			status_q    <= status_d;
			head_data_q <= hd_d;
			head_prio_q <= hp_d;
			occ_q       <= count_d;
		end
	end

	assign occ_ext       = {{spq_pkg::OCC_W{1'b0}}, occ_q};
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign head_data     = head_data_q;
	assign head_priority = head_prio_q;
	assign occupancy     = occ_ext[spq_pkg::OCC_W-1:0];

	// Valid cells form a contiguous run from the head
	a_valid_contig: assert property (@(posedge clk) disable iff (!arst_n)
		(((c_valid >> 1) & ~c_valid) == '0))
		else $error("valid cells not contiguous");

	// Count matches the number of valid cells
	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		($countones(c_valid) == int'(count_q)))
		else $error("entry count disagrees with cell valid bits");

	// A dequeue of a held entry lowers the count by one
	a_deq_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.deq |=> (count_q == $past(count_q) - 1'b1)))
		else $error("dequeue did not lower the count");

	// An accepted enqueue never lands when full
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= CAP_C))
		else $error("count above capacity");

endmodule

>>> rtl/core/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell #(
	parameter int PRIORITY_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  spq_pkg::cell_cmd_t          cmd,
	input  logic [spq_pkg::DATA_W-1:0]  new_data,
	input  logic [PRIORITY_BITS-1:0]    new_prio,
	input  logic [spq_pkg::DATA_W-1:0]  left_data,
	input  logic [PRIORITY_BITS-1:0]    left_prio,
	input  logic                        left_valid,
	input  logic                        left_greater,
	input  logic [spq_pkg::DATA_W-1:0]  right_data,
	input  logic [PRIORITY_BITS-1:0]    right_prio,
	input  logic                        right_valid,
	output logic [spq_pkg::DATA_W-1:0]  data,
	output logic [PRIORITY_BITS-1:0]    prio,
	output logic                        valid,
	output logic                        greater
);

	logic [spq_pkg::DATA_W-1:0] data_q;
	logic [PRIORITY_BITS-1:0]   prio_q;
	logic                       valid_q;
	logic [spq_pkg::DATA_W-1:0] data_d;
	logic [PRIORITY_BITS-1:0]   prio_d;
	logic                       valid_d;

	// Cell sits behind the new entry: empty or strictly larger number
	assign greater = !valid_q || (prio_q > new_prio);

	// Pick the next contents: insert here, shift right, shift left or hold
	always_comb begin
		data_d  = data_q;
		prio_d  = prio_q;
		valid_d = valid_q;
		if (cmd.enq) begin
			if (greater && !left_greater) begin
				data_d  = new_data;
				prio_d  = new_prio;
				valid_d = 1'b1;
			end else if (greater) begin
				data_d  = left_data;
				prio_d  = left_prio;
				valid_d = left_valid;
			end
		end else if (cmd.deq) begin
			data_d  = right_data;
			prio_d  = right_prio;
			valid_d = right_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	// Payload carries no reset
	always_ff @(posedge clk) begin
		data_q <= data_d;
		prio_q <= prio_d;
	end

	assign data  = data_q;
	assign prio  = prio_q;
	assign valid = valid_q;

endmodule

>>> dv/spq_result_checker.sv
`timescale 1ns / 1ps

module spq_result_checker #(
	parameter int CAPACITY      = 16,
	parameter int PRIORITY_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic [1:0]                         req_type,
	input  logic signed [spq_pkg::DATA_W-1:0]  item_data,
	input  logic [spq_pkg::PRIO_PORT_W-1:0]    item_priority,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic [1:0]                         status,
	input  logic signed [spq_pkg::DATA_W-1:0]  head_data,
	input  logic [spq_pkg::PRIO_PORT_W-1:0]    head_priority,
	input  logic [spq_pkg::OCC_W-1:0]          occupancy,
	output int                                 fail_count,
	output int                                 results_pending
);

	localparam int DW  = spq_pkg::DATA_W;
	localparam int PPW = spq_pkg::PRIO_PORT_W;
	localparam int OW  = spq_pkg::OCC_W;

	localparam logic [PPW-1:0] PRIO_MASK = (PRIORITY_BITS >= PPW) ?
		{PPW{1'b1}} : PPW'((1 << PRIORITY_BITS) - 1);

	typedef struct packed {
		spq_pkg::status_t     st;
		logic signed [DW-1:0] data;
		logic [PPW-1:0]       prio;
		logic [OW-1:0]        occ;
	} queue_result_t;

	// Shadow copy of the sorted list, head at index 0
	logic signed [DW-1:0] held_data [CAPACITY];
	logic [PPW-1:0]       held_prio [CAPACITY];
	int                   held_count;
	queue_result_t        awaited [$];
	queue_result_t        want;

	// Apply one request to the shadow list and return the result it gives
	function automatic queue_result_t serve_request(logic [1:0] rt,
			logic signed [DW-1:0] d, logic [PPW-1:0] p);
		queue_result_t  res;
		logic [PPW-1:0] pm;
		int             pos;
		res = '0;
		res.st = spq_pkg::ST_OK;
		pm = p & PRIO_MASK;
		case (rt)
			spq_pkg::REQ_ENQ: begin
				if (held_count >= CAPACITY) begin
					res.st = spq_pkg::ST_FULL;
				end else begin
					// insert behind every entry whose number is not greater
					pos = 0;
					while (pos < held_count && held_prio[pos] <= pm)
						pos++;
					for (int i = held_count; i > pos; i--) begin
						held_data[i] = held_data[i-1];
						held_prio[i] = held_prio[i-1];
					end
					held_data[pos] = d;
					held_prio[pos] = pm;
					held_count++;
				end
			end
			spq_pkg::REQ_DEQ, spq_pkg::REQ_PEEK: begin
				if (held_count == 0) begin
					res.st = spq_pkg::ST_EMPTY;
				end else begin
					res.data = held_data[0];
					res.prio = held_prio[0];
					if (rt == spq_pkg::REQ_DEQ) begin
						for (int i = 0; i + 1 < held_count; i++) begin
							held_data[i] = held_data[i+1];
							held_prio[i] = held_prio[i+1];
						end
						held_count--;
					end
				end
			end
			default: ;
		endcase
		res.occ = OW'(held_count);
		return res;
	endfunction

	task automatic note_failure(string what);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $realtime, what);
	endtask

	// Compare the outgoing transfer first, then predict the incoming one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count = 0;
			fail_count = 0;
			awaited.delete();
			results_pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited.size() == 0) begin
					note_failure($sformatf("unexpected result: status=%0d data=%0d prio=%0d occ=%0d",
						status, head_data, head_priority, occupancy));
				end else begin
					want = awaited.pop_front();
					if (status !== want.st || head_data !== want.data ||
							head_priority !== want.prio || occupancy !== want.occ)
						note_failure($sformatf({"result mismatch: expected status=%0d data=%0d ",
							"prio=%0d occ=%0d, got status=%0d data=%0d prio=%0d occ=%0d"},
							want.st, want.data, want.prio, want.occ,
							status, head_data, head_priority, occupancy));
				end
			end
			if (in_valid && !in_stall)
				awaited.push_back(serve_request(req_type, item_data, item_priority));
			results_pending <= awaited.size();
		end
	end

endmodule

>>> dv/sorted_priority_queue_top_test.sv
`timescale 1ns / 1ps

module sorted_priority_queue_top_test;

	localparam int CAPACITY      = 16;
	localparam int PRIORITY_BITS = 16;
	localparam int DW            = spq_pkg::DATA_W;
	localparam int PPW           = spq_pkg::PRIO_PORT_W;
	localparam int OW            = spq_pkg::OCC_W;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 950;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	logic [1:0]                  req_type;
	logic signed [DW-1:0]        item_data;
	logic [PPW-1:0]              item_priority;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [1:0]                  status;
	logic signed [DW-1:0]        head_data;
	logic [PPW-1:0]              head_priority;
	logic [OW-1:0]               occupancy;
	int                          fail_count;
	int                          results_pending;
	logic                        steady_run = 1'b0;

	sorted_priority_queue_top #(
		.CAPACITY      (CAPACITY),
		.PRIORITY_BITS (PRIORITY_BITS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.item_data     (item_data),
		.item_priority (item_priority),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.head_data     (head_data),
		.head_priority (head_priority),
		.occupancy     (occupancy)
	);

	spq_result_checker #(
		.CAPACITY      (CAPACITY),
		.PRIORITY_BITS (PRIORITY_BITS)
	) checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.req_type        (req_type),
		.item_data       (item_data),
		.item_priority   (item_priority),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.head_data       (head_data),
		.head_priority   (head_priority),
		.occupancy       (occupancy),
		.fail_count      (fail_count),
		.results_pending (results_pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Stall the result channel at random, except in the steady stretch
	always @(posedge clk)
		out_stall <= !steady_run && ($urandom_range(0, 99) < 22);

	// Offer one request, with random idle cycles ahead of it, and hold it until transfer
	task automatic issue_request(logic [1:0] rt, logic signed [DW-1:0] d,
			logic [PPW-1:0] p);
		while (!steady_run && $urandom_range(0, 99) < 22) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		item_data <= d;
		item_priority <= p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Drop valid and hold until every outstanding result has come back
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int             enq_pct;
		int             roll;
		logic [1:0]     rt;
		logic [PPW-1:0] p;

		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = spq_pkg::REQ_ENQ;
		item_data = '0;
		item_priority = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Underflow and the unused code on an empty queue
		issue_request(spq_pkg::REQ_PEEK, 32'sd0, 16'h0000);
		issue_request(spq_pkg::REQ_DEQ, 32'sd0, 16'hFFFF);
		issue_request(REQ_UNUSED, -32'sd1, 16'hFFFF);

		// Fill to capacity with extreme values and priority ties
		issue_request(spq_pkg::REQ_ENQ, 32'sh7FFF_FFFF, 16'hFFFF);
		issue_request(spq_pkg::REQ_ENQ, 32'sh8000_0000, 16'h0000);
		issue_request(spq_pkg::REQ_ENQ, 32'sd0, 16'd5);
		issue_request(spq_pkg::REQ_ENQ, -32'sd1, 16'd5);
		issue_request(spq_pkg::REQ_ENQ, 32'shA5A5_A5A5, 16'd5);
		issue_request(spq_pkg::REQ_ENQ, 32'sd1, 16'hFFFF);
		issue_request(spq_pkg::REQ_ENQ, 32'sd2, 16'h0000);
		issue_request(spq_pkg::REQ_ENQ, 32'sd3, 16'h8000);
		issue_request(spq_pkg::REQ_ENQ, 32'sd4, 16'h7FFF);
		issue_request(spq_pkg::REQ_ENQ, 32'sd5, 16'd1);
		issue_request(spq_pkg::REQ_ENQ, 32'sd6, 16'd5);
		issue_request(spq_pkg::REQ_ENQ, 32'sh5A5A_5A5A, 16'd5);
		issue_request(spq_pkg::REQ_ENQ, 32'sd8, 16'hFFFE);
		issue_request(spq_pkg::REQ_ENQ, 32'sd9, 16'h0000);
		issue_request(spq_pkg::REQ_ENQ, 32'sd10, 16'd3);
		issue_request(spq_pkg::REQ_ENQ, 32'sd11, 16'd3);

		// Overflow, unused code while full, then read the head
		issue_request(spq_pkg::REQ_ENQ, 32'sh1234_5678, 16'h0000);
		issue_request(REQ_UNUSED, 32'sd0, 16'h0000);
		issue_request(spq_pkg::REQ_PEEK, 32'sd0, 16'h0000);
		issue_request(spq_pkg::REQ_DEQ, 32'sd0, 16'h0000);
		issue_request(spq_pkg::REQ_DEQ, 32'sd0, 16'h0000);
		wait_for_drain();

		// Random traffic in bursts that lean toward filling or emptying the queue
		enq_pct = 50;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: enq_pct = 15;
					1: enq_pct = 50;
					default: enq_pct = 85;
				endcase
			end
			if (n == 400)
				steady_run <= 1'b1;
			if (n == 550)
				steady_run <= 1'b0;
			if (n == 475)
				wait_for_drain();

			roll = $urandom_range(0, 99);
			if (roll < 3)
				rt = REQ_UNUSED;
			else if (roll < enq_pct)
				rt = spq_pkg::REQ_ENQ;
			else if ($urandom_range(0, 3) == 0)
				rt = spq_pkg::REQ_PEEK;
			else
				rt = spq_pkg::REQ_DEQ;

			// Mostly a narrow range so equal numbers show up often
			roll = $urandom_range(0, 9);
			if (roll < 5)
				p = PPW'($urandom_range(0, 7));
			else if (roll < 8)
				p = PPW'($urandom);
			else if (roll == 8)
				p = '0;
			else
				p = '1;

			issue_request(rt, DW'($urandom), p);
		end

		wait_for_drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && results_pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Stop a hung run
	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
